[src/lbc_pkg.sv]
package lbc_pkg;

    localparam int unsigned NUM_BUFFERS_DEF = 4;
    localparam int unsigned TAG_W           = 32;
    localparam int unsigned SLOT_W          = 2;
    localparam int unsigned KIND_W          = 2;
    localparam int unsigned STATUS_W        = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET     = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_DIRTY   = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_WAIT  = 2'd1,
        STATUS_NOBUF = 2'd2
    } status_t;

    // Operation applied by a cell when it is selected.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_HIT,
        OP_CLAIM,
        OP_DIRTY,
        OP_DONE,
        OP_RELEASE
    } op_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  block_number;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_out;
        logic                hit;
        logic                needs_read;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic busy;
        logic dirty;
        logic valid;
    } flags_t;

    typedef struct packed {
        op_t               op;
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] slot;
    } cell_cmd_t;

endpackage

[src/lbc_cell.sv]
module lbc_cell #(
    parameter int unsigned NUM_BUFFERS = lbc_pkg::NUM_BUFFERS_DEF,
    parameter int unsigned POS         = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lbc_pkg::cell_cmd_t                     cmd,
    input  logic                                   sel,
    input  logic                                   shift,
    input  logic [lbc_pkg::TAG_W-1:0]              up_tag,
    input  lbc_pkg::flags_t                        up_flags,
    input  logic [$clog2(NUM_BUFFERS)-1:0]         up_id,
    output logic [lbc_pkg::TAG_W-1:0]              tag,
    output lbc_pkg::flags_t                        flags,
    output logic [$clog2(NUM_BUFFERS)-1:0]         id,
    output logic                                   tag_hit,
    output logic                                   id_hit
);
    import lbc_pkg::*;

    localparam int unsigned SW = $clog2(NUM_BUFFERS);
    localparam int unsigned CW = (SW > SLOT_W) ? SW : SLOT_W;

    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;
    flags_t           flags_reg;
    flags_t           flags_next;
    logic [SW-1:0]    id_reg;
    logic [SW-1:0]    id_next;

    // A shift takes the entry of the more recent neighbor; it wins over
    // any flag update, which never coincides with a release.
    always_comb
    begin
        tag_next   = tag_reg;
        flags_next = flags_reg;
        id_next    = id_reg;
        if (shift)
        begin
            tag_next   = up_tag;
            flags_next = up_flags;
            id_next    = up_id;
        end
        else if (sel)
        begin
            case (cmd.op)
                OP_HIT:
                begin
                    flags_next.busy = 1'b1;
                end
                OP_CLAIM:
                begin
                    tag_next         = cmd.tag;
                    flags_next.busy  = 1'b1;
                    flags_next.dirty = 1'b0;
                    flags_next.valid = 1'b0;
                end
                OP_DIRTY:
                begin
                    flags_next.dirty = 1'b1;
                end
                OP_DONE:
                begin
                    flags_next.valid = 1'b1;
                    flags_next.dirty = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            flags_reg <= '0;
            id_reg    <= SW'(POS);
        end
        else
        begin
            tag_reg   <= tag_next;
            flags_reg <= flags_next;
            id_reg    <= id_next;
        end
    end

    assign tag     = tag_reg;
    assign flags   = flags_reg;
    assign id      = id_reg;
    assign tag_hit = (tag_reg == cmd.tag);
    assign id_hit  = (CW'(id_reg) == CW'(cmd.slot));

endmodule

[src/lbc_pick.sv]
module lbc_pick #(
    parameter int unsigned NUM_BUFFERS = lbc_pkg::NUM_BUFFERS_DEF,
    parameter bit          HIGHEST     = 1'b0
) (
    input  logic [NUM_BUFFERS-1:0] req,
    output logic [NUM_BUFFERS-1:0] grant
);
    import lbc_pkg::*;

    logic [NUM_BUFFERS-1:0] ord;
    logic [NUM_BUFFERS-1:0] first;

    // Isolate the lowest set bit; the highest is found on the mirrored vector.
    always_comb
    begin
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            ord[i] = HIGHEST ? req[NUM_BUFFERS-1-i] : req[i];
        end
        first = ord & (~ord + NUM_BUFFERS'(1));
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            grant[i] = HIGHEST ? first[NUM_BUFFERS-1-i] : first[i];
        end
    end

endmodule

[src/lru_block_buffer_cache_tags.sv]
// Tag manager for a small fully associative block buffer cache. The slots sit in a row of
// cells ordered by recency, least recent at cell 0 and most recent at the last cell; each
// cell holds one slot's tag, busy, dirty and valid flags and its slot number. A get compares
// the block number in every cell at once, takes the most recent match or else claims the
// least recent slot that is neither busy nor dirty. A release shifts the cells above the
// released slot one place toward the old end and puts the slot in the newest cell. Every
// request gives exactly one response beat. A request beat is first registered, and when it
// fires all cells compare and update and the response register loads together. The block
// takes no new beat while a registered request is pending; a stalled response holds the
// pending request in place.
module lru_block_buffer_cache_tags #(
    parameter int unsigned NUM_BUFFERS = lbc_pkg::NUM_BUFFERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lbc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lbc_pkg::rsp_t rsp
);
    import lbc_pkg::*;

    localparam int unsigned SW = $clog2(NUM_BUFFERS);

    logic      op_valid_reg;
    req_t      op_reg;
    logic      rsp_valid_reg;
    rsp_t      rsp_reg;
    rsp_t      rsp_next;
    logic      accept;
    logic      fire;
    kind_t     kind;
    cell_cmd_t cmd;
    logic      release_go;

    logic [TAG_W-1:0]       tag_vec   [NUM_BUFFERS];
    flags_t                 flags_vec [NUM_BUFFERS];
    logic [SW-1:0]          id_vec    [NUM_BUFFERS];
    logic [TAG_W-1:0]       up_tag    [NUM_BUFFERS];
    flags_t                 up_flags  [NUM_BUFFERS];
    logic [SW-1:0]          up_id     [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] tag_hit;
    logic [NUM_BUFFERS-1:0] id_hit;
    logic [NUM_BUFFERS-1:0] sel_vec;
    logic [NUM_BUFFERS-1:0] shift_vec;
    logic [NUM_BUFFERS-1:0] busy_v;
    logic [NUM_BUFFERS-1:0] dirty_v;
    logic [NUM_BUFFERS-1:0] valid_v;
    logic [NUM_BUFFERS-1:0] elig;
    logic [NUM_BUFFERS-1:0] hit_sel;
    logic [NUM_BUFFERS-1:0] claim_sel;

    logic [SW-1:0]    hit_id;
    logic [SW-1:0]    claim_id;
    logic             hit_busy;
    logic             hit_valid;
    logic [TAG_W-1:0] mv_tag;
    flags_t           mv_flags;
    logic [SW-1:0]    mv_id;

    assign accept    = req_valid && !req_stall;
    assign fire      = op_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = op_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign kind      = kind_t'(op_reg.kind);

    for (genvar i = 0; i < NUM_BUFFERS; i++)
    begin : g_cell
        lbc_cell #(
            .NUM_BUFFERS (NUM_BUFFERS),
            .POS         (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .sel      (sel_vec[i]),
            .shift    (shift_vec[i]),
            .up_tag   (up_tag[i]),
            .up_flags (up_flags[i]),
            .up_id    (up_id[i]),
            .tag      (tag_vec[i]),
            .flags    (flags_vec[i]),
            .id       (id_vec[i]),
            .tag_hit  (tag_hit[i]),
            .id_hit   (id_hit[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            busy_v[i]  = flags_vec[i].busy;
            dirty_v[i] = flags_vec[i].dirty;
            valid_v[i] = flags_vec[i].valid;
        end
        elig = ~busy_v & ~dirty_v;
    end

    lbc_pick #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .HIGHEST     (1'b1)
    ) u_pick_hit (
        .req   (tag_hit),
        .grant (hit_sel)
    );

    lbc_pick #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .HIGHEST     (1'b0)
    ) u_pick_claim (
        .req   (elig),
        .grant (claim_sel)
    );

    // One-hot selects collapse to the chosen cell's contents.
    always_comb
    begin
        hit_id   = '0;
        claim_id = '0;
        mv_tag   = '0;
        mv_flags = '0;
        mv_id    = '0;
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            hit_id   = hit_id   | (id_vec[i] & {SW{hit_sel[i]}});
            claim_id = claim_id | (id_vec[i] & {SW{claim_sel[i]}});
            mv_tag   = mv_tag   | (tag_vec[i] & {TAG_W{id_hit[i]}});
            mv_flags = mv_flags | (flags_vec[i] & {$bits(flags_t){id_hit[i]}});
            mv_id    = mv_id    | (id_vec[i] & {SW{id_hit[i]}});
        end
        hit_busy  = |(hit_sel & busy_v);
        hit_valid = |(hit_sel & valid_v);
    end

    // Each cell takes its newer neighbor; the newest cell takes the released entry.
    always_comb
    begin
        for (int i = 0; i < NUM_BUFFERS - 1; i++)
        begin
            up_tag[i]   = tag_vec[i+1];
            up_flags[i] = flags_vec[i+1];
            up_id[i]    = id_vec[i+1];
        end
        up_tag[NUM_BUFFERS-1]        = mv_tag;
        up_flags[NUM_BUFFERS-1]      = mv_flags;
        up_flags[NUM_BUFFERS-1].busy = 1'b0;
        up_id[NUM_BUFFERS-1]         = mv_id;
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            shift_vec[i] = release_go && |(id_hit & ~({NUM_BUFFERS{1'b1}} << (i + 1)));
        end
    end

    always_comb
    begin
        cmd.tag    = op_reg.block_number;
        cmd.slot   = op_reg.slot;
        cmd.op     = OP_NONE;
        sel_vec    = '0;
        release_go = 1'b0;
        rsp_next.slot_out   = op_reg.slot;
        rsp_next.hit        = 1'b0;
        rsp_next.needs_read = 1'b0;
        rsp_next.status     = STATUS_OK;
        case (kind)
            KIND_GET:
            begin
                if (|tag_hit)
                begin
                    rsp_next.slot_out = SLOT_W'(hit_id);
                    rsp_next.hit      = 1'b1;
                    if (hit_busy)
                    begin
                        rsp_next.status = STATUS_WAIT;
                    end
                    else
                    begin
                        cmd.op              = OP_HIT;
                        sel_vec             = hit_sel;
                        rsp_next.needs_read = !hit_valid;
                    end
                end
                else if (|elig)
                begin
                    cmd.op              = OP_CLAIM;
                    sel_vec             = claim_sel;
                    rsp_next.slot_out   = SLOT_W'(claim_id);
                    rsp_next.needs_read = 1'b1;
                end
                else
                begin
                    rsp_next.slot_out = '0;
                    rsp_next.status   = STATUS_NOBUF;
                end
            end
            KIND_RELEASE:
            begin
                cmd.op     = OP_RELEASE;
                release_go = 1'b1;
            end
            KIND_DIRTY:
            begin
                cmd.op  = OP_DIRTY;
                sel_vec = id_hit;
            end
            KIND_DONE:
            begin
                cmd.op  = OP_DONE;
                sel_vec = id_hit;
            end
            default:
            begin
            end
        endcase
        if (!fire)
        begin
            cmd.op     = OP_NONE;
            sel_vec    = '0;
            release_go = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                op_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                op_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= '0;
            rsp_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                op_reg <= req;
            end
            if (fire)
            begin
                rsp_reg <= rsp_next;
            end
        end
    end

`ifndef SYNTHESIS
    // Slot numbers held in the cells stay a permutation.
    assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg && (32'(op_reg.slot) < NUM_BUFFERS) |-> $onehot(id_hit))
        else $error("slot number not held by exactly one cell");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel_vec) && $onehot0(hit_sel) && $onehot0(claim_sel))
        else $error("more than one cell selected");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cmd.op == OP_RELEASE) && (|id_hit)
        |=> (id_vec[NUM_BUFFERS-1] == SW'($past(op_reg.slot))))
        else $error("released slot did not become most recent");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cmd.op == OP_CLAIM)
        |=> rsp_valid && rsp.needs_read && !rsp.hit && (rsp.status == STATUS_OK))
        else $error("claimed slot response is wrong");
`endif

endmodule
